@@ hdl/rdmc_pkg.sv @@
// Shared types, register map, command/status bundles and helper functions of the maze carver.
`default_nettype none

package rdmc_pkg;

    localparam int unsigned DEF_MAX_SIDE = 32;
    localparam int unsigned GRID_SIDE_W  = 6;
    localparam int unsigned SIDE_W       = GRID_SIDE_W + 1;
    localparam int unsigned XY_W         = 5;
    localparam int unsigned RAND_W       = 16;
    localparam int unsigned WALL_W       = 4;
    localparam int unsigned APB_ADDR_W   = 3;
    localparam int unsigned APB_DATA_W   = 32;

    localparam logic [0:0]             REG_GRID_SIDE = 1'b0;
    localparam logic [GRID_SIDE_W-1:0] GRID_SIDE_RST = 6'd25;
    localparam logic [WALL_W-1:0]      WALLS_CLOSED  = 4'hF;

    localparam logic [1:0] SLOT_W = 2'd0;
    localparam logic [1:0] SLOT_E = 2'd1;
    localparam logic [1:0] SLOT_N = 2'd2;
    localparam logic [1:0] SLOT_S = 2'd3;

    typedef enum logic
    {
        KIND_START = 1'b0,
        KIND_STEP  = 1'b1
    } kind_t;

    typedef enum logic [2:0]
    {
        ST_STARTED   = 3'd0,
        ST_CARVED    = 3'd1,
        ST_DEAD_END  = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_BAD_START = 3'd4
    } status_t;

    typedef enum logic [1:0]
    {
        DIR_N = 2'd0,
        DIR_E = 2'd1,
        DIR_S = 2'd2,
        DIR_W = 2'd3
    } dir_t;

    typedef struct packed
    {
        kind_t             kind;
        logic [XY_W-1:0]   start_x;
        logic [XY_W-1:0]   start_y;
        logic [RAND_W-1:0] random_value;
    } item_t;

    typedef struct packed
    {
        status_t           status;
        logic [XY_W-1:0]   cell_x;
        logic [XY_W-1:0]   cell_y;
        logic [XY_W-1:0]   next_x;
        logic [XY_W-1:0]   next_y;
        dir_t              direction;
        logic [WALL_W-1:0] cell_walls;
        logic [WALL_W-1:0] next_walls;
        logic              done_res;
    } result_t;

    typedef struct packed
    {
        logic take_item;
        logic do_start;
        logic do_pop;
        logic sweep;
        logic rd_cur;
        logic rd_ew;
        logic rd_s;
        logic pick;
        logic wr_cur;
        logic wr_nxt;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed
    {
        logic is_start;
        logic start_ok;
        logic stack_empty;
        logic sweep_last;
        logic out_free;
    } ctrl_sts_t;

    function automatic dir_t slot_dir(input logic [1:0] slot);
        dir_t d;
        case (slot)
            SLOT_W:  d = DIR_W;
            SLOT_E:  d = DIR_E;
            SLOT_N:  d = DIR_N;
            SLOT_S:  d = DIR_S;
            default: d = DIR_N;
        endcase
        return d;
    endfunction

    function automatic logic [WALL_W-1:0] keep_next(input dir_t d);
        logic [WALL_W-1:0] k;
        case (d)
            DIR_N:   k = 4'b1101;
            DIR_E:   k = 4'b1110;
            DIR_S:   k = 4'b0111;
            DIR_W:   k = 4'b1011;
            default: k = WALLS_CLOSED;
        endcase
        return k;
    endfunction

    function automatic logic [WALL_W-1:0] keep_cur(input dir_t d);
        logic [WALL_W-1:0] k;
        case (d)
            DIR_N:   k = 4'b0111;
            DIR_E:   k = 4'b1011;
            DIR_S:   k = 4'b1101;
            DIR_W:   k = 4'b1110;
            default: k = WALLS_CLOSED;
        endcase
        return k;
    endfunction

    function automatic logic [1:0] mod3(input logic [RAND_W-1:0] v);
        logic [4:0] s;
        logic [2:0] t;
        logic [2:0] u;
        s = '0;
        for (int i = 0; i < RAND_W / 2; i++)
        begin
            s = s + 5'(v[2*i +: 2]);
        end
        t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
        u = 3'(t[1:0]) + 3'(t[2]);
        if (u >= 3'd3)
        begin
            u = u - 3'd3;
        end
        return u[1:0];
    endfunction

endpackage

`default_nettype wire

@@ hdl/rdmc_ctrl.sv @@
// Sequencing state machine of the maze carver.
`default_nettype none

module rdmc_ctrl
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  item_valid,
    output logic                       item_ready,
    input  wire rdmc_pkg::ctrl_sts_t   sts,
    output rdmc_pkg::ctrl_cmd_t        cmd
);
    import rdmc_pkg::*;

    typedef enum logic [9:0]
    {
        S_INIT   = 10'b0000000001,
        S_IDLE   = 10'b0000000010,
        S_CLEAR  = 10'b0000000100,
        S_CUR    = 10'b0000001000,
        S_RD1    = 10'b0000010000,
        S_RD2    = 10'b0000100000,
        S_PICK   = 10'b0001000000,
        S_WR_CUR = 10'b0010000000,
        S_WR_NXT = 10'b0100000000,
        S_DONE   = 10'b1000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_ready = 1'b0;
        case (state_reg)
            S_INIT:
            begin
                cmd.sweep = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.take_item = 1'b1;
                    if (sts.is_start)
                    begin
                        if (sts.start_ok)
                        begin
                            cmd.do_start = 1'b1;
                            state_next   = S_CLEAR;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                    else if (sts.stack_empty)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cmd.do_pop = 1'b1;
                        state_next = S_CUR;
                    end
                end
            end
            S_CLEAR:
            begin
                cmd.sweep = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_CUR:
            begin
                cmd.rd_cur = 1'b1;
                state_next = S_RD1;
            end
            S_RD1:
            begin
                cmd.rd_ew  = 1'b1;
                state_next = S_RD2;
            end
            S_RD2:
            begin
                cmd.rd_s   = 1'b1;
                state_next = S_PICK;
            end
            S_PICK:
            begin
                cmd.pick   = 1'b1;
                state_next = S_WR_CUR;
            end
            S_WR_CUR:
            begin
                cmd.wr_cur = 1'b1;
                state_next = S_WR_NXT;
            end
            S_WR_NXT:
            begin
                cmd.wr_nxt = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/rdmc_dp.sv @@
// Datapath of the maze carver: cell memory, cell stack, neighbour choice and result register.
`default_nettype none

module rdmc_dp
#(
    parameter int unsigned MAX_SIDE = rdmc_pkg::DEF_MAX_SIDE
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [rdmc_pkg::SIDE_W-1:0]   side,
    input  wire rdmc_pkg::item_t               item,
    input  wire rdmc_pkg::ctrl_cmd_t           cmd,
    output rdmc_pkg::ctrl_sts_t                sts,
    input  wire logic                          result_ready,
    output logic                               result_valid,
    output rdmc_pkg::result_t                  result
);
    import rdmc_pkg::*;

    localparam int unsigned CW        = $clog2(MAX_SIDE);
    localparam int unsigned AW        = 2 * CW;
    localparam int unsigned MEM_DEPTH = 1 << AW;
    localparam int unsigned CELLS     = MAX_SIDE * MAX_SIDE;
    localparam int unsigned SA        = $clog2(CELLS);
    localparam int unsigned CNT_W     = $clog2(CELLS + 1);
    localparam int unsigned ENT_W     = WALL_W + 1;

    logic [ENT_W-1:0] cell_mem  [MEM_DEPTH];
    logic [AW-1:0]    stack_mem [CELLS];

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [CNT_W-1:0]  top_idx;
    logic [AW-1:0]     sweep_reg;
    logic              res_valid_reg;
    result_t           result_reg;
    result_t           result_next;
    result_t           stage_reg;
    result_t           stage_next;

    logic [AW-1:0]     stack_q_reg;
    logic [ENT_W-1:0]  q_a_reg;
    logic [ENT_W-1:0]  q_b_reg;
    logic [AW-1:0]     rd_a_addr;
    logic [AW-1:0]     rd_b_addr;

    logic [1:0]        rand_lo_reg;
    logic [1:0]        mod3_reg;
    logic [AW-1:0]     cur_reg;
    logic [ENT_W-1:0]  cur_ent_reg;
    logic [ENT_W-1:0]  nbw_reg;
    logic [ENT_W-1:0]  nbe_reg;
    logic [ENT_W-1:0]  nbn_reg;
    logic              found_reg;
    logic [AW-1:0]     nxt_reg;
    logic [WALL_W-1:0] nxt_walls_reg;
    logic [WALL_W-1:0] cur_walls_reg;

    logic [AW-1:0]     base;
    logic [CW-1:0]     bx;
    logic [CW-1:0]     by;
    logic [AW-1:0]     nb_addr [4];
    logic [ENT_W-1:0]  nb_ent  [4];
    logic [CW-1:0]     cx;
    logic [CW-1:0]     cy;
    logic [SIDE_W-1:0] cx_s;
    logic [SIDE_W-1:0] cy_s;
    logic [3:0]        ok;
    logic [3:0]        free;
    logic [2:0]        cnt;
    logic [1:0]        pick_idx;
    logic [2:0]        seen;
    logic [1:0]        sel;
    logic              hit;
    dir_t              pick_dir;
    logic [WALL_W-1:0] pick_nxt_walls;
    logic [WALL_W-1:0] pick_cur_walls;

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [ENT_W-1:0]  wr_data;
    logic              push_en;
    logic [SA-1:0]     push_addr;
    logic [AW-1:0]     push_data;
    logic              full;
    logic              start_ok;

    // status towards the controller
    assign start_ok = (SIDE_W'(item.start_x) < side) && (SIDE_W'(item.start_y) < side);
    assign sts.is_start    = (item.kind == KIND_START);
    assign sts.start_ok    = start_ok;
    assign sts.stack_empty = (count_reg == '0);
    assign sts.sweep_last  = &sweep_reg;
    assign sts.out_free    = !res_valid_reg || result_ready;

    assign result_valid = res_valid_reg;
    assign result       = result_reg;

    // neighbour addresses around the cell being read
    assign base = cmd.rd_cur ? stack_q_reg : cur_reg;
    assign bx   = base[CW-1:0];
    assign by   = base[AW-1:CW];

    always_comb
    begin
        nb_addr[SLOT_W] = {by, bx - CW'(1)};
        nb_addr[SLOT_E] = {by, bx + CW'(1)};
        nb_addr[SLOT_N] = {by - CW'(1), bx};
        nb_addr[SLOT_S] = {by + CW'(1), bx};
    end

    assign rd_a_addr = cmd.rd_cur ? base : (cmd.rd_ew ? nb_addr[SLOT_E] : nb_addr[SLOT_S]);
    assign rd_b_addr = cmd.rd_cur ? nb_addr[SLOT_W] : nb_addr[SLOT_N];

    // neighbour choice
    assign cx   = cur_reg[CW-1:0];
    assign cy   = cur_reg[AW-1:CW];
    assign cx_s = SIDE_W'(cx);
    assign cy_s = SIDE_W'(cy);

    always_comb
    begin
        nb_ent[SLOT_W] = nbw_reg;
        nb_ent[SLOT_E] = nbe_reg;
        nb_ent[SLOT_N] = nbn_reg;
        nb_ent[SLOT_S] = q_a_reg;

        ok[SLOT_W] = (cx != '0) && ((cx_s - SIDE_W'(1)) < side) && (cy_s < side);
        ok[SLOT_E] = ((cx_s + SIDE_W'(1)) < side) && (cy_s < side);
        ok[SLOT_N] = (cy != '0) && ((cy_s - SIDE_W'(1)) < side) && (cx_s < side);
        ok[SLOT_S] = ((cy_s + SIDE_W'(1)) < side) && (cx_s < side);

        cnt = '0;
        for (int i = 0; i < 4; i++)
        begin
            free[i] = ok[i] && !nb_ent[i][WALL_W];
            cnt     = cnt + 3'(free[i]);
        end

        case (cnt)
            3'd2:    pick_idx = {1'b0, rand_lo_reg[0]};
            3'd3:    pick_idx = mod3_reg;
            3'd4:    pick_idx = rand_lo_reg;
            default: pick_idx = 2'd0;
        endcase

        seen = '0;
        sel  = SLOT_W;
        hit  = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            if (free[i])
            begin
                if (!hit && (seen == {1'b0, pick_idx}))
                begin
                    hit = 1'b1;
                    sel = 2'(i);
                end
                seen = seen + 3'd1;
            end
        end

        pick_dir       = slot_dir(sel);
        pick_nxt_walls = nb_ent[sel][WALL_W-1:0] & keep_next(pick_dir);
        pick_cur_walls = hit ? (cur_ent_reg[WALL_W-1:0] & keep_cur(pick_dir))
                             : cur_ent_reg[WALL_W-1:0];
    end

    // cell memory write port
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = sweep_reg;
        wr_data = {1'b0, WALLS_CLOSED};
        if (cmd.sweep)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.wr_cur)
        begin
            wr_en   = 1'b1;
            wr_addr = cur_reg;
            wr_data = {1'b1, cur_walls_reg};
        end
        else if (cmd.wr_nxt && found_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = nxt_reg;
            wr_data = {1'b0, nxt_walls_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            cell_mem[wr_addr] <= wr_data;
        end
        q_a_reg <= cell_mem[rd_a_addr];
        q_b_reg <= cell_mem[rd_b_addr];
    end

    // stack
    assign full    = (count_reg >= CNT_W'(CELLS));
    assign top_idx = count_reg - CNT_W'(1);

    always_comb
    begin
        push_en    = 1'b0;
        push_addr  = count_reg[SA-1:0];
        push_data  = cur_reg;
        count_next = count_reg;
        if (cmd.do_start)
        begin
            push_en    = 1'b1;
            push_addr  = '0;
            push_data  = {CW'(item.start_y), CW'(item.start_x)};
            count_next = CNT_W'(1);
        end
        else if (cmd.do_pop)
        begin
            count_next = top_idx;
        end
        else if ((cmd.wr_cur || cmd.wr_nxt) && found_reg && !full)
        begin
            push_en    = 1'b1;
            push_data  = cmd.wr_nxt ? nxt_reg : cur_reg;
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            stack_mem[push_addr] <= push_data;
        end
        if (cmd.do_pop)
        begin
            stack_q_reg <= stack_mem[top_idx[SA-1:0]];
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            sweep_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.sweep)
            begin
                sweep_reg <= sweep_reg + AW'(1);
            end
            if (cmd.load_out)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // result staging
    always_comb
    begin
        stage_next = stage_reg;
        if (cmd.take_item)
        begin
            stage_next = '0;
            if (item.kind == KIND_START)
            begin
                if (start_ok)
                begin
                    stage_next.status     = ST_STARTED;
                    stage_next.cell_x     = item.start_x;
                    stage_next.cell_y     = item.start_y;
                    stage_next.cell_walls = WALLS_CLOSED;
                end
                else
                begin
                    stage_next.status = ST_BAD_START;
                end
            end
            else
            begin
                stage_next.status = ST_EMPTY;
            end
        end
        if (cmd.pick)
        begin
            stage_next            = '0;
            stage_next.status     = hit ? ST_CARVED : ST_DEAD_END;
            stage_next.cell_x     = XY_W'(cx);
            stage_next.cell_y     = XY_W'(cy);
            stage_next.cell_walls = pick_cur_walls;
            if (hit)
            begin
                stage_next.next_x     = XY_W'(nb_addr[sel][CW-1:0]);
                stage_next.next_y     = XY_W'(nb_addr[sel][AW-1:CW]);
                stage_next.direction  = pick_dir;
                stage_next.next_walls = pick_nxt_walls;
            end
        end
        result_next          = stage_reg;
        result_next.done_res = (count_reg == '0);
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        stage_reg <= stage_next;
        if (cmd.take_item)
        begin
            rand_lo_reg <= item.random_value[1:0];
            mod3_reg    <= mod3(item.random_value);
        end
        if (cmd.rd_cur)
        begin
            cur_reg <= stack_q_reg;
        end
        if (cmd.rd_ew)
        begin
            cur_ent_reg <= q_a_reg;
            nbw_reg     <= q_b_reg;
        end
        if (cmd.rd_s)
        begin
            nbe_reg <= q_a_reg;
            nbn_reg <= q_b_reg;
        end
        if (cmd.pick)
        begin
            found_reg     <= hit;
            nxt_reg       <= nb_addr[sel];
            nxt_walls_reg <= pick_nxt_walls;
            cur_walls_reg <= pick_cur_walls;
        end
        if (cmd.load_out)
        begin
            result_reg <= result_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CELLS))
        else $error("stack count beyond capacity");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_pop |-> (count_reg != '0))
        else $error("pop from an empty stack");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!res_valid_reg || result_ready))
        else $error("result register overwritten while waiting");

    a_start_push: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_start |=> (count_reg == CNT_W'(1)))
        else $error("start did not leave a single stacked cell");

endmodule

`default_nettype wire

@@ hdl/random_dfs_maze_carver_core.sv @@
// Top level of the maze carver: register port, controller and datapath.
//
// Randomised depth-first maze carver over a square grid of up to MAX_SIDE x MAX_SIDE cells.
// Cell state (visited mark and N E S W wall mask) sits in a single-write, dual-read memory of
// 2**(2*clog2(MAX_SIDE)) entries and the walk stack in a one-read, one-write memory. A step
// word runs in order from acceptance to its result word: it pops the stack, reads the current
// cell and its four neighbours through the two read ports, chooses a neighbour, writes back
// the masks and pushes, and loads the result once the result register is free. An empty-stack
// step or a refused start goes straight to loading its result. After reset, and after every
// accepted start, a clearing pass writes every cell memory entry once, during which no word
// is accepted; the result of a start is loaded after that pass ends. A new word is accepted
// while the previous result still waits.
`default_nettype none

module random_dfs_maze_carver_core
#(
    parameter int unsigned MAX_SIDE = rdmc_pkg::DEF_MAX_SIDE
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [rdmc_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [rdmc_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [rdmc_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                   pready,
    input  wire logic                              item_valid,
    output logic                                   item_ready,
    input  wire rdmc_pkg::item_t                   item,
    output logic                                   result_valid,
    input  wire logic                              result_ready,
    output rdmc_pkg::result_t                      result
);
    import rdmc_pkg::*;

    logic [GRID_SIDE_W-1:0] grid_side_reg;
    logic [SIDE_W-1:0]      side;
    logic                   reg_sel;
    ctrl_cmd_t              cmd;
    ctrl_sts_t              sts;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[APB_ADDR_W-1:2] == REG_GRID_SIDE);
    assign prdata  = reg_sel ? APB_DATA_W'(grid_side_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_side_reg <= GRID_SIDE_RST;
        end
        else if (psel && penable && pwrite && pready && reg_sel)
        begin
            grid_side_reg <= pwdata[GRID_SIDE_W-1:0];
        end
    end

    // saturate the side to the grid capacity
    assign side = (SIDE_W'(grid_side_reg) > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE)
                                                               : SIDE_W'(grid_side_reg);

    rdmc_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    rdmc_dp
    #(
        .MAX_SIDE (MAX_SIDE)
    )
    u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .side         (side),
        .item         (item),
        .cmd          (cmd),
        .sts          (sts),
        .result_ready (result_ready),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

`default_nettype wire

@@ dv/random_dfs_maze_carver_core_test.sv @@
// Self-checking bench for the maze carver: a directed table, then random walks, checked by a predictor.
module random_dfs_maze_carver_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rdmc_pkg::*;

    localparam int unsigned GRID_MAX      = DEF_MAX_SIDE;
    localparam int unsigned CELL_COUNT    = GRID_MAX * GRID_MAX;
    localparam int unsigned PLAN_ROWS     = 25;
    localparam int unsigned RANDOM_WORDS  = 1700;
    localparam int unsigned SETTLE_CYCLES = 12;
    localparam int unsigned DRAIN_CYCLES  = 24;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned QUIET_LIMIT   = 8000;

    localparam logic [APB_ADDR_W-1:0] SIDE_ADDR = APB_ADDR_W'(4 * int'(REG_GRID_SIDE));

    localparam result_t NO_RESULT    = '0;
    localparam result_t EMPTY_STACK  =
        '{ST_EMPTY, 5'd0, 5'd0, 5'd0, 5'd0, DIR_N, 4'h0, 4'h0, 1'b1};
    localparam result_t REFUSED_IDLE =
        '{ST_BAD_START, 5'd0, 5'd0, 5'd0, 5'd0, DIR_N, 4'h0, 4'h0, 1'b1};

    typedef struct
    {
        bit                     wr_side;
        logic [GRID_SIDE_W-1:0] side;
        item_t                  word;
        bit                     typed;
        result_t                want;
    } plan_row_t;

    plan_row_t plan [PLAN_ROWS] = '{
        '{1'b0, 6'd0,  '{KIND_STEP,  5'd0,  5'd0,  16'h0000}, 1'b1, EMPTY_STACK},
        '{1'b0, 6'd0,  '{KIND_START, 5'd25, 5'd3,  16'h0000}, 1'b1, REFUSED_IDLE},
        '{1'b0, 6'd0,  '{KIND_START, 5'd3,  5'd25, 16'h0000}, 1'b1, REFUSED_IDLE},
        '{1'b0, 6'd0,  '{KIND_START, 5'd31, 5'd31, 16'hFFFF}, 1'b1, REFUSED_IDLE},
        '{1'b0, 6'd0,  '{KIND_START, 5'd24, 5'd24, 16'h0000}, 1'b1,
          '{ST_STARTED, 5'd24, 5'd24, 5'd0, 5'd0, DIR_N, 4'hF, 4'h0, 1'b0}},
        '{1'b0, 6'd0,  '{KIND_STEP,  5'd31, 5'd31, 16'hFFFF}, 1'b0, NO_RESULT},
        '{1'b0, 6'd0,  '{KIND_STEP,  5'd0,  5'd0,  16'h0000}, 1'b0, NO_RESULT},
        '{1'b1, 6'd3,  '{KIND_STEP,  5'd0,  5'd0,  16'h1234}, 1'b0, NO_RESULT},
        '{1'b0, 6'd0,  '{KIND_STEP,  5'd0,  5'd0,  16'h0001}, 1'b0, NO_RESULT},
        '{1'b1, 6'd0,  '{KIND_START, 5'd0,  5'd0,  16'h0000}, 1'b0, NO_RESULT},
        '{1'b1, 6'd1,  '{KIND_START, 5'd0,  5'd0,  16'h0000}, 1'b1,
          '{ST_STARTED, 5'd0, 5'd0, 5'd0, 5'd0, DIR_N, 4'hF, 4'h0, 1'b0}},
        '{1'b0, 6'd0,  '{KIND_STEP,  5'd0,  5'd0,  16'hFFFF}, 1'b1,
          '{ST_DEAD_END, 5'd0, 5'd0, 5'd0, 5'd0, DIR_N, 4'hF, 4'h0, 1'b1}},
        '{1'b0, 6'd0,  '{KIND_STEP,  5'd0,  5'd0,  16'h0000}, 1'b1, EMPTY_STACK},
        '{1'b1, 6'd63, '{KIND_START, 5'd31, 5'd31, 16'h0000}, 1'b1,
          '{ST_STARTED, 5'd31, 5'd31, 5'd0, 5'd0, DIR_N, 4'hF, 4'h0, 1'b0}},
        '{1'b0, 6'd0,  '{KIND_STEP,  5'd0,  5'd0,  16'h0000}, 1'b0, NO_RESULT},
        '{1'b0, 6'd0,  '{KIND_STEP,  5'd0,  5'd0,  16'hFFFF}, 1'b0, NO_RESULT},
        '{1'b0, 6'd0,  '{KIND_STEP,  5'd0,  5'd0,  16'h7FFF}, 1'b0, NO_RESULT},
        '{1'b1, 6'd32, '{KIND_START, 5'd31, 5'd0,  16'h0000}, 1'b1,
          '{ST_STARTED, 5'd31, 5'd0, 5'd0, 5'd0, DIR_N, 4'hF, 4'h0, 1'b0}},
        '{1'b0, 6'd0,  '{KIND_STEP,  5'd0,  5'd0,  16'h0003}, 1'b0, NO_RESULT},
        '{1'b1, 6'd2,  '{KIND_START, 5'd2,  5'd0,  16'h0000}, 1'b0, NO_RESULT},
        '{1'b0, 6'd0,  '{KIND_START, 5'd1,  5'd1,  16'h0000}, 1'b1,
          '{ST_STARTED, 5'd1, 5'd1, 5'd0, 5'd0, DIR_N, 4'hF, 4'h0, 1'b0}},
        '{1'b0, 6'd0,  '{KIND_STEP,  5'd0,  5'd0,  16'h0002}, 1'b0, NO_RESULT},
        '{1'b0, 6'd0,  '{KIND_STEP,  5'd0,  5'd0,  16'h0004}, 1'b0, NO_RESULT},
        '{1'b0, 6'd0,  '{KIND_STEP,  5'd0,  5'd0,  16'h0006}, 1'b0, NO_RESULT},
        '{1'b0, 6'd0,  '{KIND_STEP,  5'd0,  5'd0,  16'h0008}, 1'b0, NO_RESULT}
    };

    logic                   clk;
    logic                   rst_n        = 1'b0;
    logic                   psel         = 1'b0;
    logic                   penable      = 1'b0;
    logic                   pwrite       = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr        = '0;
    logic [APB_DATA_W-1:0]  pwdata       = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;
    logic                   item_valid   = 1'b0;
    logic                   item_ready;
    item_t                  item_word    = '0;
    logic                   result_valid;
    logic                   result_ready = 1'b0;
    result_t                result_word;

    logic [GRID_SIDE_W-1:0] side_reg     = GRID_SIDE_RST;
    bit                     seen [CELL_COUNT];
    logic [WALL_W-1:0]      walls [CELL_COUNT];
    bit [9:0]               cell_stack [CELL_COUNT];
    int unsigned            stack_depth  = 0;

    result_t                carve_backlog [$];
    int unsigned            words_sent     = 0;
    int unsigned            mismatch_count = 0;
    int unsigned            quiet_cycles   = 0;
    bit                     calm_phase     = 1'b0;

    random_dfs_maze_carver_core dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item_word),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result_word)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic void push_cell(input int unsigned idx);
        if (stack_depth < CELL_COUNT)
        begin
            cell_stack[stack_depth] = 10'(idx);
            stack_depth++;
        end
    endfunction

    function automatic result_t predict_carve(input item_t w);
        result_t     r;
        int unsigned span, cur, cx, cy, cnt, pick, nxt;
        int unsigned cand_idx [4];
        dir_t        cand_dir [4];
        dir_t        d;

        r = '0;
        span = (side_reg > GRID_MAX) ? GRID_MAX : int'(side_reg);
        if (w.kind == KIND_START)
        begin
            if (int'(w.start_x) >= span || int'(w.start_y) >= span)
            begin
                r.status = ST_BAD_START;
            end
            else
            begin
                for (int i = 0; i < CELL_COUNT; i++)
                begin
                    seen[i] = 1'b0;
                    walls[i] = WALLS_CLOSED;
                end
                stack_depth = 0;
                push_cell(int'(w.start_y) * GRID_MAX + int'(w.start_x));
                r.status = ST_STARTED;
                r.cell_x = w.start_x;
                r.cell_y = w.start_y;
                r.cell_walls = WALLS_CLOSED;
            end
        end
        else if (stack_depth == 0)
        begin
            r.status = ST_EMPTY;
        end
        else
        begin
            stack_depth--;
            cur = int'(cell_stack[stack_depth]);
            cx = cur % GRID_MAX;
            cy = cur / GRID_MAX;
            seen[cur] = 1'b1;
            cnt = 0;
            if (cx > 0 && cx - 1 < span && cy < span && !seen[cur - 1])
            begin
                cand_idx[cnt] = cur - 1;
                cand_dir[cnt] = DIR_W;
                cnt++;
            end
            if (cx + 1 < span && cy < span && !seen[cur + 1])
            begin
                cand_idx[cnt] = cur + 1;
                cand_dir[cnt] = DIR_E;
                cnt++;
            end
            if (cy > 0 && cy - 1 < span && cx < span && !seen[cur - GRID_MAX])
            begin
                cand_idx[cnt] = cur - GRID_MAX;
                cand_dir[cnt] = DIR_N;
                cnt++;
            end
            if (cy + 1 < span && cx < span && !seen[cur + GRID_MAX])
            begin
                cand_idx[cnt] = cur + GRID_MAX;
                cand_dir[cnt] = DIR_S;
                cnt++;
            end
            r.cell_x = 5'(cx);
            r.cell_y = 5'(cy);
            if (cnt > 0)
            begin
                pick = int'(w.random_value) % cnt;
                nxt = cand_idx[pick];
                d = cand_dir[pick];
                // wall bits run N E S W from bit 3 down; the neighbour loses the opposite one
                walls[cur][3 - int'(d)] = 1'b0;
                walls[nxt][3 - int'(dir_t'(d ^ 2'd2))] = 1'b0;
                push_cell(cur);
                push_cell(nxt);
                r.status = ST_CARVED;
                r.next_x = 5'(nxt % GRID_MAX);
                r.next_y = 5'(nxt / GRID_MAX);
                r.direction = d;
                r.next_walls = walls[nxt];
            end
            else
            begin
                r.status = ST_DEAD_END;
            end
            r.cell_walls = walls[cur];
        end
        r.done_res = (stack_depth == 0);
        return r;
    endfunction

    function automatic item_t step_word();
        item_t w;
        w.kind = KIND_STEP;
        w.start_x = 5'($urandom);
        w.start_y = 5'($urandom);
        w.random_value = 16'($urandom);
        return w;
    endfunction

    function automatic item_t start_word(input int unsigned span, input bit in_grid);
        item_t w;
        w = step_word();
        w.kind = KIND_START;
        if ((in_grid && span > 0) || span >= GRID_MAX)
        begin
            w.start_x = 5'($urandom_range(0, span - 1));
            w.start_y = 5'($urandom_range(0, span - 1));
        end
        else if (span > 0 && $urandom_range(0, 2) != 0)
        begin
            if ($urandom_range(0, 1) == 0)
                w.start_x = 5'($urandom_range(span, GRID_MAX - 1));
            else
                w.start_y = 5'($urandom_range(span, GRID_MAX - 1));
        end
        return w;
    endfunction

    function automatic int unsigned sender_gap();
        return calm_phase ? 0 : $urandom_range(0, 10);
    endfunction

    task automatic send_word(input item_t w, input result_t want, input int unsigned gap);
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_word <= w;
        item_valid <= 1'b1;
        do @(posedge clk); while (!item_ready);
        carve_backlog.push_back(want);
        words_sent++;
    endtask

    task automatic set_grid_side(input logic [GRID_SIDE_W-1:0] v);
        item_valid <= 1'b0;
        while (carve_backlog.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= SIDE_ADDR;
        pwdata <= APB_DATA_W'(v);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        side_reg = v;
    endtask

    task automatic check_field(input string what, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0d got %0d", $time, what, want, got);
            mismatch_count++;
        end
    endtask

    initial
    begin : stimulus
        item_t                  w;
        result_t                want;
        int unsigned            span, budget, phase_base, roll;
        logic [GRID_SIDE_W-1:0] new_side;

        for (int i = 0; i < CELL_COUNT; i++)
        begin
            walls[i] = WALLS_CLOSED;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].wr_side)
                set_grid_side(plan[i].side);
            want = predict_carve(plan[i].word);
            if (plan[i].typed)
                want = plan[i].want;
            send_word(plan[i].word, want, $urandom_range(0, 10));
        end

        while (words_sent < PLAN_ROWS + RANDOM_WORDS)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 58)
                new_side = 6'($urandom_range(3, 6));
            else if (roll < 73)
                new_side = 6'($urandom_range(7, 12));
            else if (roll < 79)
                new_side = 6'($urandom_range(13, 31));
            else if (roll < 85)
                new_side = 6'($urandom_range(0, 2));
            else if (roll < 88)
                new_side = 6'd32;
            else if (roll < 91)
                new_side = 6'($urandom_range(33, 63));
            else
                new_side = side_reg;
            if (new_side != side_reg)
                set_grid_side(new_side);
            span = (side_reg > GRID_MAX) ? GRID_MAX : int'(side_reg);
            calm_phase = ($urandom_range(0, 3) == 0);
            budget = $urandom_range(40, 250);
            phase_base = words_sent;

            // leave the old walk running now and then, so it continues on the new side
            if ($urandom_range(0, 9) != 0)
            begin
                w = start_word(span, 1'b1);
                send_word(w, predict_carve(w), sender_gap());
            end
            while (words_sent - phase_base < budget && words_sent < PLAN_ROWS + RANDOM_WORDS)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 4)
                    w = start_word(span, 1'b0);
                else if (roll < 7)
                    w = start_word(span, 1'b1);
                else if (roll < 10)
                begin
                    w = step_word();
                    w.kind = kind_t'($urandom_range(0, 1));
                end
                else
                    w = step_word();
                send_word(w, predict_carve(w), sender_gap());
                if (w.kind == KIND_STEP && stack_depth == 0)
                begin
                    repeat ($urandom_range(0, 2))
                    begin
                        w = step_word();
                        send_word(w, predict_carve(w), sender_gap());
                    end
                    break;
                end
            end
        end

        item_valid <= 1'b0;
        while (carve_backlog.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin : result_sink
        int unsigned taken, pause;

        taken = 0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            // hold off long enough for the block to back up into its input
            if (taken % 500 == 300)
                pause = HOLD_CYCLES;
            else if ((taken / 64) % 6 == 5)
                pause = 0;
            else
                pause = $urandom_range(0, 10);
            if (pause != 0)
            begin
                result_ready <= 1'b0;
                repeat (pause) @(posedge clk);
            end
            result_ready <= 1'b1;
            do @(posedge clk); while (!result_valid);
            taken++;
        end
    end

    always @(posedge clk)
    begin : result_check
        result_t want;

        if (rst_n && result_valid && result_ready)
        begin
            if (carve_backlog.size() == 0)
            begin
                $display("%0t: result word expected none, got %p", $time, result_word);
                mismatch_count++;
            end
            else
            begin
                want = carve_backlog.pop_front();
                check_field("status", want.status, result_word.status);
                check_field("cell_x", want.cell_x, result_word.cell_x);
                check_field("cell_y", want.cell_y, result_word.cell_y);
                check_field("next_x", want.next_x, result_word.next_x);
                check_field("next_y", want.next_y, result_word.next_y);
                check_field("direction", want.direction, result_word.direction);
                check_field("cell_walls", want.cell_walls, result_word.cell_walls);
                check_field("next_walls", want.next_walls, result_word.next_walls);
                check_field("done_res", want.done_res, result_word.done_res);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule
